// ===== hw/rtl/msort_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sorter package
// Shared types and constants for the merge sorter core and its submodules.
// ----------------------------------------------------------------------------
package msort_pkg;

   // Default capacity of one set.
   localparam int MAX_ITEMS_DEF = 64;

   // Width of one stored value.
   localparam int DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] item_value;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT_PRIME,
      ST_MERGE,
      ST_EMIT_PRIME,
      ST_EMIT
   } state_type;

   // Control from the sequencer to the datapath in the top level.
   typedef struct packed {
      logic wr_en_a;    // write the primary store
      logic wr_en_b;    // write the scratch store
      logic wr_load;    // write data comes from the request
      logic take_left;  // merged value comes from the left run
      logic src_sel;    // 0: primary store is the source, 1: scratch
      logic rsp_load;   // load the response register
      logic rsp_last;   // the loaded response closes the set
   } ctrl_type;

endpackage

// ===== hw/rtl/merge_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sorter core
// Loads a set of signed values, sorts it stably by bottom-up merging between
// two RAMs and returns the values in ascending order.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  item_value, is_last
//   rsp_     out        rsp_valid/rsp_ready  sorted_value, last_of_run
//
// Loading accepts a request whenever the core is in its load state. For a
// set of n values the sort takes ceil(log2 n) merge passes, each opened by a
// priming state; emission then primes the read port and returns the values.
// The pass time is set by the single write port of each RAM, which takes one
// merged value per cycle. Reset is synchronous and returns the core to loading
// with an empty set; RAM contents are not cleared. A stalled response holds
// the emission pointer, and no request is accepted while a set is sorted.
//
module merge_sorter_core #(
   parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  msort_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output msort_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);

   msort_pkg::ctrl_type ctrl;

   logic [AW-1:0] rd0_addr;
   logic [AW-1:0] rd1_addr;
   logic [AW-1:0] wr_addr;

   logic signed [msort_pkg::DATA_W-1:0] a_rd0;
   logic signed [msort_pkg::DATA_W-1:0] a_rd1;
   logic signed [msort_pkg::DATA_W-1:0] b_rd0;
   logic signed [msort_pkg::DATA_W-1:0] b_rd1;
   logic signed [msort_pkg::DATA_W-1:0] rd_left;
   logic signed [msort_pkg::DATA_W-1:0] rd_right;
   logic signed [msort_pkg::DATA_W-1:0] wr_data;

   logic               rsp_valid_ff, rsp_valid_in;
   msort_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               rsp_busy;

   // The source RAM of the current pass feeds both run heads; emission reads
   // through the left port.
   assign rd_left  = ctrl.src_sel ? b_rd0 : a_rd0;
   assign rd_right = ctrl.src_sel ? b_rd1 : a_rd1;

   // The primary RAM takes loaded requests; otherwise both RAMs take the
   // merged value, and only the destination of the pass is enabled.
   assign wr_data = ctrl.wr_load   ? req_data.item_value :
                    ctrl.take_left ? rd_left : rd_right;

   // The response register frees as soon as the waiting response is taken.
   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   msort_seq #(
      .MAX_ITEMS (MAX_ITEMS),
      .AW        (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_data.is_last),
      .req_ready   (req_ready),
      .rsp_busy    (rsp_busy),
      .rd_left     (rd_left),
      .rd_right    (rd_right),
      .rd0_addr    (rd0_addr),
      .rd1_addr    (rd1_addr),
      .wr_addr     (wr_addr),
      .ctrl        (ctrl)
   );

   msort_ram #(
      .DEPTH (MAX_ITEMS),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (ctrl.wr_en_a),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .rd0_data (a_rd0),
      .rd1_data (a_rd1)
   );

   msort_ram #(
      .DEPTH (MAX_ITEMS),
      .AW    (AW)
   ) u_scratch (
      .clock    (clock),
      .wr_en    (ctrl.wr_en_b),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .rd0_data (b_rd0),
      .rd1_data (b_rd1)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_value = rd_left;
         rsp_data_in.last_of_run  = ctrl.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A merge step writes only the destination RAM of its pass.
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.wr_en_a && ctrl.wr_en_b))
      else $error("both RAMs written in one cycle");

   // A new response is never loaded over one that is still waiting.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while stalled");

   // Loading and emission never overlap.
   a_load_emit_apart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !ctrl.rsp_load)
      else $error("request accepted during emission");

   // The final response of a set hands the core back to loading.
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (ctrl.rsp_load && ctrl.rsp_last) |=> req_ready)
      else $error("core not ready for a new set after the last response");

endmodule

// ===== hw/rtl/msort_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sorter RAM
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module msort_ram #(
   parameter int DEPTH = msort_pkg::MAX_ITEMS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [AW-1:0]                          wr_addr,
   input  logic signed [msort_pkg::DATA_W-1:0]    wr_data,
   input  logic [AW-1:0]                          rd0_addr,
   input  logic [AW-1:0]                          rd1_addr,
   output logic signed [msort_pkg::DATA_W-1:0]    rd0_data,
   output logic signed [msort_pkg::DATA_W-1:0]    rd1_data
);

   logic signed [msort_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic signed [msort_pkg::DATA_W-1:0] rd0_data_ff;
   logic signed [msort_pkg::DATA_W-1:0] rd1_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd0_data_ff <= mem_ff[rd0_addr];
      rd1_data_ff <= mem_ff[rd1_addr];
   end

   assign rd0_data = rd0_data_ff;
   assign rd1_data = rd1_data_ff;

endmodule

// ===== hw/rtl/msort_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge sorter sequencer
// Load, bottom-up merge pass and emission control with run pointers.
// ----------------------------------------------------------------------------
module msort_seq #(
   parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF,
   parameter int AW        = $clog2(MAX_ITEMS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_is_last,
   output logic                                req_ready,
   input  logic                                rsp_busy,
   input  logic signed [msort_pkg::DATA_W-1:0] rd_left,
   input  logic signed [msort_pkg::DATA_W-1:0] rd_right,
   output logic [AW-1:0]                       rd0_addr,
   output logic [AW-1:0]                       rd1_addr,
   output logic [AW-1:0]                       wr_addr,
   output msort_pkg::ctrl_type                 ctrl
);

   // Counters hold values up to the set size; sums of run bounds need two more bits.
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = $clog2(MAX_ITEMS) + 1;
   localparam int SW = CW + 2;

   msort_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] k_ff, k_in;
   logic [WW-1:0] w_ff, w_in;
   logic          sel_ff, sel_in;

   logic [CW-1:0] n_start;
   logic [WW-1:0] w_dbl;
   logic [SW-1:0] sum_mid;
   logic [SW-1:0] sum_hi;
   logic [SW-1:0] sum_hi_next;
   logic          left_ok;
   logic          right_ok;
   logic          take_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msort_pkg::ST_LOAD;
         count_ff <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      k_ff   <= k_in;
      w_ff   <= w_in;
   end

   always_comb begin
      n_start     = (count_ff == CW'(MAX_ITEMS)) ? count_ff : count_ff + CW'(1);
      w_dbl       = {w_ff[WW-2:0], 1'b0};
      sum_mid     = SW'(hi_ff) + SW'(w_ff);
      sum_hi      = SW'(hi_ff) + (SW'(w_ff) << 1);
      sum_hi_next = SW'(w_dbl) << 1;
      left_ok     = i_ff < mid_ff;
      right_ok    = j_ff < hi_ff;
      take_left   = left_ok && (!right_ok || (rd_left <= rd_right));

      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      mid_in    = mid_ff;
      hi_in     = hi_ff;
      k_in      = k_ff;
      w_in      = w_ff;
      sel_in    = sel_ff;
      req_ready = 1'b0;
      wr_addr   = k_ff[AW-1:0];
      ctrl      = '0;
      ctrl.src_sel = sel_ff;

      case (state_ff)
         msort_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            wr_addr   = count_ff[AW-1:0];
            if (req_valid) begin
               // A request arriving on a full store is dropped and closes the set.
               if (count_ff != CW'(MAX_ITEMS)) begin
                  ctrl.wr_en_a = 1'b1;
                  ctrl.wr_load = 1'b1;
                  count_in     = count_ff + CW'(1);
               end
               if (req_is_last || (count_ff == CW'(MAX_ITEMS))) begin
                  count_in = n_start;
                  i_in     = '0;
                  k_in     = '0;
                  w_in     = WW'(1);
                  j_in     = CW'(1);
                  mid_in   = CW'(1);
                  hi_in    = (n_start == CW'(1)) ? CW'(1) : CW'(2);
                  sel_in   = 1'b0;
                  state_in = (n_start == CW'(1)) ? msort_pkg::ST_EMIT_PRIME
                                                 : msort_pkg::ST_SORT_PRIME;
               end
            end
         end
         msort_pkg::ST_SORT_PRIME: begin
            state_in = msort_pkg::ST_MERGE;
         end
         msort_pkg::ST_MERGE: begin
            ctrl.take_left = take_left;
            ctrl.wr_en_a   = sel_ff;
            ctrl.wr_en_b   = !sel_ff;
            k_in           = k_ff + CW'(1);
            if (take_left) begin
               i_in = i_ff + CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
            if ((k_ff + CW'(1)) == count_ff) begin
               // Pass complete: swap source and destination, double the run width.
               sel_in = !sel_ff;
               w_in   = w_dbl;
               i_in   = '0;
               k_in   = '0;
               j_in   = CW'(w_dbl);
               mid_in = CW'(w_dbl);
               hi_in  = (sum_hi_next < SW'(count_ff)) ? CW'(sum_hi_next) : count_ff;
               if (SW'(count_ff) <= SW'(w_dbl)) begin
                  state_in = msort_pkg::ST_EMIT_PRIME;
               end else begin
                  state_in = msort_pkg::ST_SORT_PRIME;
               end
            end else if ((k_ff + CW'(1)) == hi_ff) begin
               // Next pair of runs starts where this one ended.
               i_in   = hi_ff;
               mid_in = (sum_mid < SW'(count_ff)) ? CW'(sum_mid) : count_ff;
               j_in   = (sum_mid < SW'(count_ff)) ? CW'(sum_mid) : count_ff;
               hi_in  = (sum_hi < SW'(count_ff)) ? CW'(sum_hi) : count_ff;
            end
         end
         msort_pkg::ST_EMIT_PRIME: begin
            state_in = msort_pkg::ST_EMIT;
         end
         msort_pkg::ST_EMIT: begin
            if (!rsp_busy) begin
               ctrl.rsp_load = 1'b1;
               ctrl.rsp_last = (i_ff + CW'(1)) == count_ff;
               i_in          = i_ff + CW'(1);
               if ((i_ff + CW'(1)) == count_ff) begin
                  count_in = '0;
                  state_in = msort_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = msort_pkg::ST_LOAD;
         end
      endcase
   end

   // Reads are issued from the next pointer values so data lines up with the registered pointers.
   assign rd0_addr = i_in[AW-1:0];
   assign rd1_addr = j_in[AW-1:0];

endmodule
